>>> rtl/phz_pkg.sv
// shared types, constants and helpers for the point hazard zone classifier
`default_nettype none
package phz_pkg;

  localparam int MAX_LINES        = 8;
  localparam int MAX_CURVE_POINTS = 64;

  localparam int REQ_W     = 2;
  localparam int LINE_W    = $clog2(MAX_LINES);
  localparam int PIDX_W    = $clog2(MAX_CURVE_POINTS);
  localparam int LEN_W     = PIDX_W + 1;
  localparam int COORD_W   = 24;
  localparam int RAD_W     = 23;
  localparam int RAD2_W    = 2 * RAD_W;
  localparam int DIST_W    = 52;
  localparam int CLASS_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam int ADDR_W    = LINE_W + PIDX_W;
  localparam int DEPTH     = MAX_LINES * MAX_CURVE_POINTS;
  localparam int WORD_W    = 3 * COORD_W;

  // datapath widths
  localparam int OPND_W    = COORD_W + 2;       // coordinate difference plus negate headroom
  localparam int PROD_W    = 2 * OPND_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SQ_W      = 51;                // squared distances, chord length, dot
  localparam int DOTX_W    = SQ_W + 5;          // room for 11 * len2
  localparam int HALF_W    = 25;
  localparam int CROSS_W   = 2 * HALF_W;        // magnitude of one cross component
  localparam int ACC_W     = 2 * CROSS_W + 2;
  localparam int QUO_W     = SQ_W;
  localparam int DCNT_W    = $clog2(QUO_W + 1);
  localparam int ZONE_W    = 4;

  // n / 10 as a multiply by reciprocal, exact for n up to 1028
  localparam int RECIP10    = 205;
  localparam int RECIP10_SH = 11;
  localparam int RECIP_W    = LEN_W + 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [REQ_W-1:0] REQ_LOAD     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLASSIFY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DANGER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd3;

  localparam logic [RAD_W-1:0] DANGER_RST  = 23'd768;
  localparam logic [RAD_W-1:0] WARNING_RST = 23'd2048;
  localparam logic [RAD_W-1:0] END_RST     = 23'd512;
  localparam logic [RAD_W-1:0] HEIGHT_RST  = 23'd1280;

  localparam logic [CLASS_W-1:0] CLS_END     = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_DANGER  = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_WARNING = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_SAFE    = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_OUTSIDE = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic [LINE_W-1:0]         line_index;
    logic [PIDX_W-1:0]         point_index;
    logic                      last_point;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } req_t;

  typedef struct packed {
    logic [CLASS_W-1:0] point_class;
    logic [DIST_W-1:0]  min_axis_dist_sq;
  } res_t;

  typedef enum logic [1:0] {OP_LOAD, OP_CLASSIFY, OP_CLEAR} op_t;

  typedef struct packed {
    op_t                       op;
    logic [LINE_W-1:0]         line;
    logic [PIDX_W-1:0]         pidx;
    logic                      last;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } cmd_t;

  typedef struct packed {
    logic signed [OPND_W-1:0] a0;
    logic signed [OPND_W-1:0] b0;
    logic signed [OPND_W-1:0] a1;
    logic signed [OPND_W-1:0] b1;
    logic signed [OPND_W-1:0] a2;
    logic signed [OPND_W-1:0] b2;
  } mac_op_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [QUO_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CABLE, S_FIRST, S_LAST, S_ZRD, S_ISSUE, S_WAIT, S_COLLECT,
    S_ENDCHK, S_DECIDE, S_DSTART, S_DIV, S_BEST, S_FIN
  } fsm_t;

  typedef enum logic [3:0] {
    ST_ZONE, ST_LEN, ST_V2, ST_DOT, ST_LASTD, ST_CX, ST_CY, ST_CZ,
    ST_HH, ST_HL, ST_LL
  } step_t;

  function automatic logic signed [OPND_W-1:0] sub_ext(
    logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
    logic signed [OPND_W-1:0] r;
    r = OPND_W'(a) - OPND_W'(b);
    return r;
  endfunction

  function automatic logic [ZONE_W-1:0] zone_of(logic [LEN_W-1:0] n);
    logic [RECIP_W-1:0] p;
    logic [RECIP_W-1:0] q;
    p = RECIP_W'(n) * RECIP_W'(RECIP10);
    q = p >> RECIP10_SH;
    if (q == '0) q = RECIP_W'(1);
    return q[ZONE_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/phz_front.sv
// front end: input register and request decode
`default_nettype none
module phz_front import phz_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_full,
  output cmd_t cmd
);

  logic f_valid;
  cmd_t f_cmd;
  cmd_t dec;
  logic ok;
  logic take;

  always_comb begin
    dec.line = req.line_index;
    dec.pidx = req.point_index;
    dec.last = req.last_point;
    dec.x    = req.coord_x;
    dec.y    = req.coord_y;
    dec.z    = req.coord_z;
    case (req.req_type)
      REQ_LOAD: begin
        dec.op = OP_LOAD;
        // out of range loads are dropped here
        ok = ({1'b0, req.line_index} < (LINE_W+1)'(MAX_LINES)) &&
             ({1'b0, req.point_index} < (PIDX_W+1)'(MAX_CURVE_POINTS));
      end
      REQ_CLASSIFY: begin
        dec.op = OP_CLASSIFY;
        ok = 1'b1;
      end
      REQ_CLEAR: begin
        dec.op = OP_CLEAR;
        ok = 1'b1;
      end
      default: begin
        dec.op = OP_CLASSIFY;
        ok = 1'b0;
      end
    endcase
  end

  assign req_stall = f_valid & cmd_full;
  assign take      = req_valid & ~req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= ok;
    end else if (f_valid && !cmd_full) begin
      f_valid <= 1'b0;
    end
    if (take) f_cmd <= dec;
  end

  assign cmd_valid = f_valid;
  assign cmd       = f_cmd;

endmodule
`default_nettype wire

>>> rtl/phz_queue.sv
// small command queue between front end and sequencer
`default_nettype none
module phz_queue import phz_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic full,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              do_pop;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign push      = push_valid & ~full;
  assign do_pop    = pop & pop_valid;
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

>>> rtl/phz_mac.sv
// three lane multiply and sum unit, products and sum both registered
`default_nettype none
module phz_mac import phz_pkg::*; (
  input  logic                    clk,
  input  mac_op_t                 op,
  output logic signed [SUM_W-1:0] sum
);

  logic signed [PROD_W-1:0] p0;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;

  always_ff @(posedge clk) begin
    p0  <= op.a0 * op.b0;
    p1  <= op.a1 * op.b1;
    p2  <= op.a2 * op.b2;
    sum <= SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
  end

endmodule
`default_nettype wire

>>> rtl/phz_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module phz_div import phz_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic [QUO_W-1:0]  rem;
  logic [QUO_W-1:0]  shreg;
  logic [QUO_W-1:0]  dvs;
  logic [DCNT_W-1:0] cnt;
  logic              running;
  logic [QUO_W:0]    trial;
  logic              fits;

  assign trial = {rem, shreg[QUO_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= DCNT_W'(QUO_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
    if (req.start) begin
      // quotient is known to fit, so the top part starts below the divisor
      rem   <= req.dividend[ACC_W-1:QUO_W];
      shreg <= req.dividend[QUO_W-1:0];
      dvs   <= req.divisor;
      quo   <= '0;
    end else if (running) begin
      rem   <= fits ? QUO_W'(trial - {1'b0, dvs}) : trial[QUO_W-1:0];
      shreg <= shreg << 1;
      quo   <= {quo[QUO_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> rtl/phz_back.sv
// back end: curve store, config registers and the classify sequencer
`default_nettype none
module phz_back import phz_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  cmd_t                 q_cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAD_W-1:0]     cfg_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res
);

  fsm_t  state, state_next;
  step_t step;

  logic [RAD_W-1:0]  danger_radius, warn_radius, end_radius, height_tolerance;
  logic [RAD2_W-1:0] dr2, wr2, er2;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_q;
  logic              mem_we;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic [LEN_W-1:0]  len [MAX_LINES];
  logic [LINE_W-1:0] c;
  logic [LEN_W-1:0]  n;
  logic [ZONE_W-1:0] zone, zi;
  logic              zb;
  logic [LEN_W-1:0]  back_off;

  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [COORD_W-1:0] fx, fy, fz, lx, ly, lz;
  logic signed [COORD_W-1:0] qx, qy, qz;

  logic [SQ_W-1:0]          min_front, min_back, len2, v2, d2, zone_d;
  logic signed [SQ_W-1:0]   dot;
  logic [CROSS_W-1:0]       cabs0, cabs1, cabs2, cr_abs;
  logic [ACC_W-1:0]         acc;
  logic [DIST_W-1:0]        best;
  logic                     at_end, in_corr;
  logic [COORD_W:0]         hdiff_f, hdiff_l;
  logic signed [DOTX_W-1:0] dot10, lenx, len11, dotx;
  logic                     out_free;

  mac_op_t                 mop;
  logic signed [SUM_W-1:0] sum;
  div_req_t                dreq;
  logic                    ddone;
  logic [QUO_W-1:0]        quo;

  phz_mac u_mac (.clk(clk), .op(mop), .sum(sum));
  phz_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quo(quo));

  assign n        = len[c];
  assign back_off = n - LEN_W'(zone) + LEN_W'(zi);
  assign qx       = mem_q[3*COORD_W-1:2*COORD_W];
  assign qy       = mem_q[2*COORD_W-1:COORD_W];
  assign qz       = mem_q[COORD_W-1:0];
  assign zone_d   = sum[SQ_W-1:0];
  assign cr_abs   = sum[SUM_W-1] ? CROSS_W'(-sum) : CROSS_W'(sum);
  assign out_free = ~res_valid | ~res_stall;

  // height differences to the chord endpoints, magnitude only
  always_comb begin
    hdiff_f = (pz >= fz) ? (COORD_W+1)'(OPND_W'(pz) - OPND_W'(fz))
                         : (COORD_W+1)'(OPND_W'(fz) - OPND_W'(pz));
    hdiff_l = (pz >= lz) ? (COORD_W+1)'(OPND_W'(pz) - OPND_W'(lz))
                         : (COORD_W+1)'(OPND_W'(lz) - OPND_W'(pz));
  end

  // corridor test terms
  assign dotx  = DOTX_W'(dot);
  assign dot10 = (dotx <<< 3) + (dotx <<< 1);
  assign lenx  = $signed(DOTX_W'(len2));
  assign len11 = (lenx <<< 3) + (lenx <<< 1) + lenx;

  // radius squares follow the config registers
  always_ff @(posedge clk) begin
    dr2 <= RAD2_W'(danger_radius) * RAD2_W'(danger_radius);
    wr2 <= RAD2_W'(warn_radius) * RAD2_W'(warn_radius);
    er2 <= RAD2_W'(end_radius) * RAD2_W'(end_radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      danger_radius    <= DANGER_RST;
      warn_radius      <= WARNING_RST;
      end_radius       <= END_RST;
      height_tolerance <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DANGER:  danger_radius    <= cfg_data;
        CFG_WARNING: warn_radius      <= cfg_data;
        CFG_END:     end_radius       <= cfg_data;
        CFG_HEIGHT:  height_tolerance <= cfg_data;
        default:     danger_radius    <= danger_radius;
      endcase
    end
  end

  // curve store
  assign mem_we = (state == S_IDLE) && q_valid && (q_cmd.op == OP_LOAD);

  always_ff @(posedge clk) begin
    if (mem_we) mem[{q_cmd.line, q_cmd.pidx}] <= {q_cmd.x, q_cmd.y, q_cmd.z};
    if (rd_en) mem_q <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (q_valid && q_cmd.op == OP_CLASSIFY) state_next = S_CABLE;
      S_CABLE: begin
        if (n < LEN_W'(2)) begin
          state_next = (c == LINE_W'(MAX_LINES - 1)) ? S_FIN : S_CABLE;
        end else begin
          state_next = S_FIRST;
        end
      end
      S_FIRST:  state_next = S_LAST;
      S_LAST:   state_next = S_ZRD;
      S_ZRD:    state_next = S_ISSUE;
      S_ISSUE:  state_next = S_WAIT;
      S_WAIT:   state_next = S_COLLECT;
      S_COLLECT: begin
        case (step)
          ST_ZONE:  state_next = (zb && zi == zone - 1'b1) ? S_ENDCHK : S_ZRD;
          ST_DOT:   state_next = S_DECIDE;
          ST_LASTD: state_next = S_BEST;
          ST_LL:    state_next = S_DSTART;
          default:  state_next = S_ISSUE;
        endcase
      end
      S_ENDCHK: state_next = S_ISSUE;
      S_DECIDE: begin
        if (len2 == '0 || dot <= 0) state_next = S_BEST;
        else state_next = S_ISSUE;
      end
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (ddone) state_next = S_BEST;
      S_BEST:   state_next = (c == LINE_W'(MAX_LINES - 1)) ? S_FIN : S_CABLE;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs: queue pop, store reads, unit operands
  always_comb begin
    q_pop         = (state == S_IDLE) && q_valid;
    rd_en         = 1'b0;
    rd_addr       = {c, PIDX_W'(0)};
    mop           = '0;
    dreq.start    = (state == S_DSTART);
    dreq.dividend = acc;
    dreq.divisor  = len2;
    case (state)
      S_CABLE: rd_en = 1'b1;
      S_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = {c, PIDX_W'(n - 1'b1)};
      end
      S_ZRD: begin
        rd_en   = 1'b1;
        rd_addr = zb ? {c, back_off[PIDX_W-1:0]} : {c, PIDX_W'(zi)};
      end
      S_ISSUE: begin
        case (step)
          ST_ZONE: begin
            mop.a0 = sub_ext(px, qx); mop.b0 = sub_ext(px, qx);
            mop.a1 = sub_ext(py, qy); mop.b1 = sub_ext(py, qy);
            mop.a2 = sub_ext(pz, qz); mop.b2 = sub_ext(pz, qz);
          end
          ST_LEN: begin
            mop.a0 = sub_ext(lx, fx); mop.b0 = sub_ext(lx, fx);
            mop.a1 = sub_ext(ly, fy); mop.b1 = sub_ext(ly, fy);
            mop.a2 = sub_ext(lz, fz); mop.b2 = sub_ext(lz, fz);
          end
          ST_V2: begin
            mop.a0 = sub_ext(px, fx); mop.b0 = sub_ext(px, fx);
            mop.a1 = sub_ext(py, fy); mop.b1 = sub_ext(py, fy);
            mop.a2 = sub_ext(pz, fz); mop.b2 = sub_ext(pz, fz);
          end
          ST_DOT: begin
            mop.a0 = sub_ext(px, fx); mop.b0 = sub_ext(lx, fx);
            mop.a1 = sub_ext(py, fy); mop.b1 = sub_ext(ly, fy);
            mop.a2 = sub_ext(pz, fz); mop.b2 = sub_ext(lz, fz);
          end
          ST_LASTD: begin
            mop.a0 = sub_ext(px, lx); mop.b0 = sub_ext(px, lx);
            mop.a1 = sub_ext(py, ly); mop.b1 = sub_ext(py, ly);
            mop.a2 = sub_ext(pz, lz); mop.b2 = sub_ext(pz, lz);
          end
          ST_CX: begin
            // vy*lz - vz*ly
            mop.a0 = sub_ext(py, fy);  mop.b0 = sub_ext(lz, fz);
            mop.a1 = -sub_ext(pz, fz); mop.b1 = sub_ext(ly, fy);
          end
          ST_CY: begin
            // vz*lx - vx*lz
            mop.a0 = sub_ext(pz, fz);  mop.b0 = sub_ext(lx, fx);
            mop.a1 = -sub_ext(px, fx); mop.b1 = sub_ext(lz, fz);
          end
          ST_CZ: begin
            // vx*ly - vy*lx
            mop.a0 = sub_ext(px, fx);  mop.b0 = sub_ext(ly, fy);
            mop.a1 = -sub_ext(py, fy); mop.b1 = sub_ext(lx, fx);
          end
          ST_HH: begin
            mop.a0 = $signed({1'b0, cabs0[CROSS_W-1:HALF_W]});
            mop.b0 = $signed({1'b0, cabs0[CROSS_W-1:HALF_W]});
            mop.a1 = $signed({1'b0, cabs1[CROSS_W-1:HALF_W]});
            mop.b1 = $signed({1'b0, cabs1[CROSS_W-1:HALF_W]});
            mop.a2 = $signed({1'b0, cabs2[CROSS_W-1:HALF_W]});
            mop.b2 = $signed({1'b0, cabs2[CROSS_W-1:HALF_W]});
          end
          ST_HL: begin
            mop.a0 = $signed({1'b0, cabs0[CROSS_W-1:HALF_W]});
            mop.b0 = $signed({1'b0, cabs0[HALF_W-1:0]});
            mop.a1 = $signed({1'b0, cabs1[CROSS_W-1:HALF_W]});
            mop.b1 = $signed({1'b0, cabs1[HALF_W-1:0]});
            mop.a2 = $signed({1'b0, cabs2[CROSS_W-1:HALF_W]});
            mop.b2 = $signed({1'b0, cabs2[HALF_W-1:0]});
          end
          ST_LL: begin
            mop.a0 = $signed({1'b0, cabs0[HALF_W-1:0]});
            mop.b0 = $signed({1'b0, cabs0[HALF_W-1:0]});
            mop.a1 = $signed({1'b0, cabs1[HALF_W-1:0]});
            mop.b1 = $signed({1'b0, cabs1[HALF_W-1:0]});
            mop.a2 = $signed({1'b0, cabs2[HALF_W-1:0]});
            mop.b2 = $signed({1'b0, cabs2[HALF_W-1:0]});
          end
          default: mop = '0;
        endcase
      end
      default: rd_en = 1'b0;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      for (int i = 0; i < MAX_LINES; i++) len[i] <= '0;
    end else begin
      state     <= state_next;
      // new result when the register frees up, old one held while stalled
      res_valid <= (state == S_FIN && out_free) || (res_valid && res_stall);
      if (state == S_IDLE && q_valid) begin
        case (q_cmd.op)
          OP_LOAD:  if (q_cmd.last) len[q_cmd.line] <= LEN_W'(q_cmd.pidx) + 1'b1;
          OP_CLEAR: for (int i = 0; i < MAX_LINES; i++) len[i] <= '0;
          default:  len[0] <= len[0];
        endcase
      end
    end

    case (state)
      S_IDLE: begin
        px      <= q_cmd.x;
        py      <= q_cmd.y;
        pz      <= q_cmd.z;
        best    <= '1;
        at_end  <= 1'b0;
        in_corr <= 1'b0;
        c       <= '0;
      end
      S_CABLE: begin
        zone      <= zone_of(n);
        zi        <= '0;
        zb        <= 1'b0;
        min_front <= '1;
        min_back  <= '1;
        if (n < LEN_W'(2)) c <= c + 1'b1;
      end
      S_FIRST: begin
        fx <= qx; fy <= qy; fz <= qz;
      end
      S_LAST: begin
        lx <= qx; ly <= qy; lz <= qz;
      end
      S_ZRD:  step <= ST_ZONE;
      S_COLLECT: begin
        case (step)
          ST_ZONE: begin
            if (!zb) begin
              if (zone_d < min_front) min_front <= zone_d;
              zb <= 1'b1;
            end else begin
              if (zone_d < min_back) min_back <= zone_d;
              zb <= 1'b0;
              zi <= zi + 1'b1;
            end
          end
          ST_LEN: begin
            len2 <= sum[SQ_W-1:0];
            step <= ST_V2;
          end
          ST_V2: begin
            v2   <= sum[SQ_W-1:0];
            step <= ST_DOT;
          end
          ST_DOT:   dot <= sum[SQ_W-1:0];
          ST_LASTD: d2  <= sum[SQ_W-1:0];
          ST_CX: begin
            cabs0 <= cr_abs;
            step  <= ST_CY;
          end
          ST_CY: begin
            cabs1 <= cr_abs;
            step  <= ST_CZ;
          end
          ST_CZ: begin
            cabs2 <= cr_abs;
            step  <= ST_HH;
          end
          ST_HH: begin
            acc  <= ACC_W'(sum) << (2 * HALF_W);
            step <= ST_HL;
          end
          ST_HL: begin
            acc  <= acc + (ACC_W'(sum) << (HALF_W + 1));
            step <= ST_LL;
          end
          ST_LL:   acc <= acc + ACC_W'(sum);
          default: step <= step;
        endcase
      end
      S_ENDCHK: begin
        // near an end zone and close in height to that endpoint
        if ((SQ_W'(min_front) < SQ_W'(er2)) && (hdiff_f < (COORD_W+1)'(height_tolerance)))
          at_end <= 1'b1;
        if ((SQ_W'(min_back) < SQ_W'(er2)) && (hdiff_l < (COORD_W+1)'(height_tolerance)))
          at_end <= 1'b1;
        step <= ST_LEN;
      end
      S_DECIDE: begin
        if (len2 == '0) begin
          in_corr <= 1'b1;
          d2      <= v2;
        end else begin
          if (dot10 >= -lenx && dot10 <= len11) in_corr <= 1'b1;
          if (dot <= 0) d2 <= v2;
          else if (dotx >= lenx) step <= ST_LASTD;
          else step <= ST_CX;
        end
      end
      S_DIV:  if (ddone) d2 <= quo;
      S_BEST: begin
        if (DIST_W'(d2) < best) best <= DIST_W'(d2);
        c <= c + 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          res.min_axis_dist_sq <= best;
          if (at_end) res.point_class <= CLS_END;
          else if (!in_corr) res.point_class <= CLS_OUTSIDE;
          else if (best <= DIST_W'(dr2)) res.point_class <= CLS_DANGER;
          else if (best <= DIST_W'(wr2)) res.point_class <= CLS_WARNING;
          else res.point_class <= CLS_SAFE;
        end
      end
      default: c <= c;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/point_hazard_zone_classifier.sv
// top level: point hazard zone classifier
// load and clear items retire in the idle state when the sequencer pops them; a
// classify item walks every cable: one with at least 2 points gets its end zones
// scanned and its chord measured, then a cross product and divide if the point
// projects inside the chord or a far end distance past it; short ones are skipped.
// one item at a time; rst is synchronous: counts, radii, queue and result
// handshake clear, points stay
`default_nettype none
module point_hazard_zone_classifier import phz_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAD_W-1:0]     cfg_data
);

  // front end to queue
  logic cmd_valid;
  logic cmd_full;
  cmd_t cmd;

  // queue to sequencer
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // registers are always writable
  assign cfg_ready = 1'b1;

  phz_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_full  (cmd_full),
    .cmd       (cmd)
  );

  // decouples decode from the long classify walk
  phz_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .full       (cmd_full),
    .push_cmd   (cmd),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd)
  );

  // curve store, radii and the per cable sequencer with its result register
  phz_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // no result right after reset
  a_no_res_after_rst: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // a corridor class needs at least one real chord, so the distance is finite
  a_level_has_dist: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.point_class == CLS_DANGER || res.point_class == CLS_WARNING ||
                  res.point_class == CLS_SAFE)
    |-> res.min_axis_dist_sq != {DIST_W{1'b1}})
    else $error("level class without a chord distance");

  // codes above outside never appear
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.point_class <= CLS_OUTSIDE)
    else $error("class code out of range");

endmodule
`default_nettype wire
